[rtl/idp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package idp_pkg;

  // PROM layout positions (odd-address bytes, counted from zero)
  localparam int unsigned IdentLen   = 4;
  localparam logic [7:0]  PosManuf   = 8'd4;
  localparam logic [7:0]  PosModel   = 8'd5;
  localparam logic [7:0]  PosUsed    = 8'd10;
  localparam logic [7:0]  PosCrc     = 8'd11;
  localparam logic [7:0]  PosMax     = 8'hFF;
  localparam logic [7:0]  MinBytes   = 8'd12;

  // CRC snapshots kept for the first bytes of a read
  localparam int unsigned HistDepth  = 11;
  localparam int unsigned HistIdxW   = $clog2(HistDepth);
  localparam logic [7:0]  HistDepthB = 8'(HistDepth);

  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;

  // Configuration register indexes
  localparam int unsigned CfgIdxW      = 8;
  localparam logic [CfgIdxW-1:0] CfgExpManuf = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgExpModel = CfgIdxW'(1);

  // "IPAC"
  localparam logic [IdentLen-1:0][7:0] IdentText = {8'h43, 8'h41, 8'h50, 8'h49};

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MODULE = 3'd1,
    ST_NOT_IPAC  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_BAD_CRC   = 3'd4,
    ST_WRONG_MOD = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first;
    logic       last;
    logic       bus_error;
  } in_beat_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] computed_crc;
    logic [7:0] found_manufacturer;
    logic [7:0] found_model;
  } out_beat_t;

  // Input register contents handed to the core
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } stage_t;

  // Running state of one PROM read
  typedef struct packed {
    logic [7:0]  pos;
    logic [15:0] crc;
    logic        ident_ok;
    logic        fault;
    logic [7:0]  manuf;
    logic [7:0]  model;
    logic [7:0]  bytes_used;
    logic [7:0]  stored_crc;
  } read_state_t;

  localparam read_state_t ReadClear = '{
    pos:        8'd0,
    crc:        CrcInit,
    ident_ok:   1'b1,
    fault:      1'b0,
    manuf:      8'd0,
    model:      8'd0,
    bytes_used: 8'd0,
    stored_crc: 8'd0
  };

  // One byte of CRC-16, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/idp_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module idp_in_stage
  import idp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t in_data_i,
  output stage_t        stage_o,
  input  wire logic     take_i
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     accept;

  // Stall only while the held beat cannot move on
  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

`default_nettype wire

[rtl/idp_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module idp_core
  import idp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire stage_t     stage_i,
  output logic            take_o,
  input  wire logic [7:0] exp_manuf_i,
  input  wire logic [7:0] exp_model_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_beat_t       out_data_o
);

  read_state_t st_q, st_d, eff, nxt;
  logic [15:0] hist_q [HistDepth];
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, res;
  logic [7:0]  pos, b, count, used;
  logic        crc_en, commit;
  logic [15:0] crc_sel;
  logic [HistIdxW-1:0] hist_idx;
  logic [7:0]  computed;

  // A beat without last always moves; a last beat needs a free result slot
  assign take_o = stage_i.valid &
                  (~stage_i.beat.last | ~out_valid_q | ~out_stall_i);
  assign commit = stage_i.valid & take_o;

  // Update the running state with the held byte
  always_comb begin
    eff      = stage_i.beat.first ? ReadClear : st_q;
    pos      = eff.pos;
    b        = stage_i.beat.byte_value;
    nxt      = eff;
    nxt.fault = eff.fault | stage_i.beat.bus_error;
    if (pos < 8'(IdentLen) && b != IdentText[pos[1:0]]) begin
      nxt.ident_ok = 1'b0;
    end
    if (pos == PosManuf) begin
      nxt.manuf = b;
    end
    if (pos == PosModel) begin
      nxt.model = b;
    end
    if (pos == PosUsed) begin
      nxt.bytes_used = b;
    end
    if (pos == PosCrc) begin
      nxt.stored_crc = b;
    end
    crc_en = (pos < HistDepthB) || (pos != PosMax && pos < nxt.bytes_used);
    if (crc_en) begin
      nxt.crc = crc_byte(eff.crc, (pos == PosCrc) ? 8'd0 : b);
    end
    if (pos != PosMax) begin
      nxt.pos = pos + 8'd1;
    end
  end

  // Pick the CRC over the first bytes-used bytes
  always_comb begin
    count    = nxt.pos;
    used     = nxt.bytes_used;
    hist_idx = HistIdxW'(used - 8'd1);
    crc_sel  = nxt.crc;
    if (used == 8'd0) begin
      crc_sel = CrcInit;
    end else if (used <= HistDepthB && used <= count) begin
      // the snapshot for this very byte is not stored yet: bypass it
      crc_sel = (used == count) ? nxt.crc : hist_q[hist_idx];
    end
    computed = ~crc_sel[7:0];
  end

  // Build the result beat, highest priority first
  always_comb begin
    res.computed_crc       = computed;
    res.found_manufacturer = nxt.manuf;
    res.found_model        = nxt.model;
    priority if (nxt.fault) begin
      res.status = ST_NO_MODULE;
    end else if (!nxt.ident_ok) begin
      res.status = ST_NOT_IPAC;
    end else if (count < MinBytes || count < used) begin
      res.status = ST_TRUNCATED;
    end else if (computed != nxt.stored_crc) begin
      res.status = ST_BAD_CRC;
    end else if (nxt.manuf != exp_manuf_i || nxt.model != exp_model_i) begin
      res.status = ST_WRONG_MOD;
    end else begin
      res.status = ST_OK;
    end
  end

  // Re-arm after the last byte of a read
  always_comb begin
    st_d = st_q;
    if (commit) begin
      st_d = stage_i.beat.last ? ReadClear : nxt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit && stage_i.beat.last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ReadClear;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Save CRC snapshots and the result payload
  always_ff @(posedge clk_i) begin
    if (commit && pos < HistDepthB) begin
      hist_q[pos[HistIdxW-1:0]] <= nxt.crc;
    end
    if (commit && stage_i.beat.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A committed last beat always lands in the result register
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && stage_i.beat.last |=> out_valid_q)
    else $error("last beat did not produce a result");

  // A finished read leaves cleared state behind
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && stage_i.beat.last |=> st_q.pos == 8'd0 && st_q.crc == CrcInit)
    else $error("state not re-armed after last beat");

  // Position advances by one per mid-read byte
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !stage_i.beat.last && !stage_i.beat.first && st_q.pos != PosMax
    |=> st_q.pos == $past(st_q.pos) + 8'd1)
    else $error("byte position did not advance");

endmodule

`default_nettype wire

[rtl/id_prom_crc_validator_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// ID PROM validator: feed the odd-address PROM bytes of one read in order, flag the
// first with first and the final one with last; one status beat comes out per read.
// A byte is taken every cycle while no last byte waits; a read's result is presented from
// the result register once its last byte has left the input register (one input register,
// one result register, with the CRC-16 byte step and the status checks as combinational
// logic between them). Only a last byte waits when the result register is still full and
// stalled. Write the expected manufacturer and model registers while no read is in flight.

module id_prom_crc_validator_top
  import idp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_beat_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_beat_t               out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  stage_t     stage;
  logic       take;
  logic [7:0] exp_manuf_q, exp_model_q;

  // Configuration writes complete at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_manuf_q <= 8'd0;
      exp_model_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgExpManuf) begin
        exp_manuf_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgExpModel) begin
        exp_model_q <= cfg_data_i;
      end
    end
  end

  idp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .stage_o    (stage),
    .take_i     (take)
  );

  idp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .take_o      (take),
    .exp_manuf_i (exp_manuf_q),
    .exp_model_i (exp_model_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/id_prom_crc_validator_checker.sv]
`timescale 1ns / 1ps

module id_prom_crc_validator_checker
  import idp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire in_beat_t           in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire out_beat_t          out_data_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int unsigned SnapDepth = 11;
  localparam int unsigned CrcPos    = 11;
  localparam int unsigned MinLen    = 12;
  localparam logic [15:0] CrcSeed   = 16'hFFFF;
  localparam logic [15:0] CrcGen    = 16'h1021;
  localparam logic [3:0][7:0] IdentBytes = {8'h43, 8'h41, 8'h50, 8'h49};

  // Expected identity registers
  logic [7:0]  want_manuf;
  logic [7:0]  want_model;

  // Running state of the read in progress
  logic [7:0]  rd_pos;
  logic [15:0] rd_crc;
  logic [15:0] crc_snap [SnapDepth];
  logic        rd_ident_ok;
  logic        rd_fault;
  logic [7:0]  rd_manuf;
  logic [7:0]  rd_model;
  logic [7:0]  rd_used;
  logic [7:0]  rd_stored;

  out_beat_t   due_results [$];
  int          mismatches;

  // CRC-16, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcGen) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_read();
    rd_pos      = 8'd0;
    rd_crc      = CrcSeed;
    for (int k = 0; k < SnapDepth; k++) begin
      crc_snap[k] = '0;
    end
    rd_ident_ok = 1'b1;
    rd_fault    = 1'b0;
    rd_manuf    = 8'd0;
    rd_model    = 8'd0;
    rd_used     = 8'd0;
    rd_stored   = 8'd0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Fold one accepted beat into the read; queue the status on last
  task automatic take_byte(input in_beat_t b);
    int unsigned idx;
    int unsigned used;
    logic [15:0] crc_pick;
    out_beat_t   res;
    if (b.first) begin
      clear_read();
    end
    idx = rd_pos;
    if (b.bus_error) begin
      rd_fault = 1'b1;
    end
    if (idx < 4 && b.byte_value != IdentBytes[idx[1:0]]) begin
      rd_ident_ok = 1'b0;
    end
    case (idx)
      4:  rd_manuf  = b.byte_value;
      5:  rd_model  = b.byte_value;
      10: rd_used   = b.byte_value;
      11: rd_stored = b.byte_value;
      default: ;
    endcase
    // Header bytes always enter the CRC; later ones only up to bytes-used
    if (idx < SnapDepth || (idx < 255 && idx < rd_used)) begin
      rd_crc = crc_update(rd_crc, (idx == CrcPos) ? 8'h00 : b.byte_value);
      if (idx < SnapDepth) begin
        crc_snap[idx] = rd_crc;
      end
    end
    if (rd_pos != 8'hFF) begin
      rd_pos++;
    end
    if (b.last) begin
      used = rd_used;
      if (used == 0) begin
        crc_pick = CrcSeed;
      end else if (used <= SnapDepth && used <= rd_pos) begin
        crc_pick = crc_snap[used - 1];
      end else begin
        crc_pick = rd_crc;
      end
      res.computed_crc       = ~crc_pick[7:0];
      res.found_manufacturer = rd_manuf;
      res.found_model        = rd_model;
      if (rd_fault) begin
        res.status = ST_NO_MODULE;
      end else if (!rd_ident_ok) begin
        res.status = ST_NOT_IPAC;
      end else if (rd_pos < MinLen || rd_pos < used) begin
        res.status = ST_TRUNCATED;
      end else if (res.computed_crc != rd_stored) begin
        res.status = ST_BAD_CRC;
      end else if (rd_manuf != want_manuf || rd_model != want_model) begin
        res.status = ST_WRONG_MOD;
      end else begin
        res.status = ST_OK;
      end
      due_results.push_back(res);
      clear_read();
    end
  endtask

  // Compare one result beat with the oldest queued status
  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result beat with no read pending, status %0d", got.status));
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status: expected %0d got %0d", want.status, got.status));
      end
      if (got.computed_crc !== want.computed_crc) begin
        report_mismatch($sformatf("computed_crc: expected %02h got %02h",
                                  want.computed_crc, got.computed_crc));
      end
      if (got.found_manufacturer !== want.found_manufacturer) begin
        report_mismatch($sformatf("found_manufacturer: expected %02h got %02h",
                                  want.found_manufacturer, got.found_manufacturer));
      end
      if (got.found_model !== want.found_model) begin
        report_mismatch($sformatf("found_model: expected %02h got %02h",
                                  want.found_model, got.found_model));
      end
    end
  endtask

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_manuf = 8'd0;
      want_model = 8'd0;
      clear_read();
      due_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgExpManuf: want_manuf = cfg_data_i;
          CfgExpModel: want_model = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        take_byte(in_data_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

[tb/sv/tb_id_prom_crc_validator_top.sv]
`timescale 1ns / 1ps

module tb_id_prom_crc_validator_top;
  import idp_pkg::*;

  localparam int CyclesMax     = 200000;
  localparam int HoldCycles    = 300;
  localparam int ItemsPerPhase = 250;
  localparam int PromMax       = 300;
  localparam int NumPhases     = 6;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_beat_t           in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_beat_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data  = '0;

  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  logic               hold_go = 1'b0;
  int                 hold_left;
  int                 cycles = 0;
  int                 items_sent = 0;
  logic [7:0]         cur_manuf = 8'd0;
  logic [7:0]         cur_model = 8'd0;
  logic [7:0]         prom [PromMax];

  id_prom_crc_validator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  id_prom_crc_validator_checker status_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  // Stall the result side at random, or hold off for a long stretch on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CyclesMax) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // Offer one beat after a random gap; return once it is taken
  task automatic send_beat(input logic [7:0] value, input logic first, input logic last,
                           input logic berr);
    in_beat_t b;
    b.byte_value = value;
    b.first      = first;
    b.last       = last;
    b.bus_error  = berr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Drop valid and wait until every status has come back, plus the pipeline depth
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both identity registers with an unused index in between
  task automatic program_regs(input logic [7:0] manuf, input logic [7:0] model);
    logic [CfgIdxW-1:0] idx [3];
    logic [7:0]         val [3];
    idx[0] = CfgExpManuf;
    val[0] = manuf;
    idx[1] = CfgIdxW'($urandom_range(2, 255));
    val[1] = 8'($urandom);
    idx[2] = CfgExpModel;
    val[2] = model;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    cur_manuf = manuf;
    cur_model = model;
  endtask

  // Fill a well-formed PROM image with a matching stored CRC
  task automatic build_good(input logic [7:0] manuf, input logic [7:0] model, input int used);
    logic [15:0] crc;
    for (int i = 0; i < PromMax; i++) begin
      prom[i] = 8'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      prom[i] = IdentText[i];
    end
    prom[4]  = manuf;
    prom[5]  = model;
    prom[10] = 8'(used);
    prom[11] = 8'h00;
    crc = 16'hFFFF;
    for (int i = 0; i < used; i++) begin
      crc = crc16_step(crc, prom[i]);
    end
    prom[11] = ~crc[7:0];
  endtask

  task automatic send_image(input int len, input int err_at, input bit with_first);
    for (int i = 0; i < len; i++) begin
      send_beat(prom[i], with_first && i == 0, i == len - 1, i == err_at);
    end
  endtask

  // Mostly well-formed reads, some broken ones, a little noise
  task automatic random_read();
    int kind;
    int pick;
    int used;
    int len;
    int err_at;
    bit with_first;
    kind   = $urandom_range(99);
    err_at = -1;
    if (kind < 70) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        used = $urandom_range(0, 11);
      end else if (pick < 10) begin
        used = $urandom_range(200, 255);
      end else begin
        used = $urandom_range(12, 32);
      end
      if ($urandom_range(99) < 85) begin
        build_good(cur_manuf, cur_model, used);
      end else begin
        build_good(8'($urandom), 8'($urandom), used);
      end
      len = (used > 12) ? used : 12;
      if ($urandom_range(3) == 0) begin
        len += $urandom_range(1, 4);
      end
      if ($urandom_range(99) < 8) begin
        len = $urandom_range(1, len - 1);
      end
      if ($urandom_range(99) < 8) begin
        prom[11] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(99) < 5) begin
        prom[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(99) < 5) begin
        err_at = $urandom_range(len - 1);
      end
      with_first = ($urandom_range(9) != 0);
      send_image(len, err_at, with_first);
    end else if (kind < 90) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        prom[i] = 8'($urandom);
      end
      if ($urandom_range(1) == 1) begin
        for (int i = 0; i < 4; i++) begin
          prom[i] = IdentText[i];
        end
      end
      for (int i = 0; i < len; i++) begin
        send_beat(prom[i], i == 0 || $urandom_range(9) == 0, i == len - 1,
                  $urandom_range(9) == 0);
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_beat(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    logic [7:0] manuf;
    logic [7:0] model;
    bit         paused;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: faulted one-byte read, a good read, then zero bytes used after re-arm
    program_regs(8'h00, 8'hFF);
    send_beat(8'h00, 1'b1, 1'b1, 1'b1);
    build_good(8'h00, 8'hFF, 12);
    send_image(12, -1, 1'b1);
    build_good(8'h00, 8'hFF, 0);
    send_image(12, -1, 1'b0);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  stall_pct <= 0;  manuf = 8'h00; model = 8'h00;
        end
        1: begin
          send_idle_pct = 80; stall_pct <= 0;  manuf = 8'hFF; model = 8'hFF;
        end
        2: begin
          send_idle_pct = 0;  stall_pct <= 80; manuf = 8'($urandom); model = 8'($urandom);
        end
        3: begin
          send_idle_pct = 34; stall_pct <= 34; manuf = 8'h00; model = 8'hFF;
        end
        4: begin
          send_idle_pct = 0;  stall_pct <= 0;  manuf = 8'hFF; model = 8'h00;
        end
        default: begin
          send_idle_pct = 34; stall_pct <= 34; manuf = 8'($urandom); model = 8'($urandom);
        end
      endcase
      program_regs(manuf, model);

      if (ph == 0) begin
        // Hold off the result side and keep pushing short reads into the block
        in_valid <= 1'b0;
        hold_go  <= 1'b1;
        @(posedge clk);
        hold_go  <= 1'b0;
        repeat (12) begin
          send_beat(8'($urandom), 1'b1, 1'b1, 1'b0);
        end
        // Long read past the position counter's saturation point
        build_good(cur_manuf, cur_model, 255);
        send_image(260, -1, 1'b1);
      end

      items_sent = 0;
      paused     = 1'b0;
      while (items_sent < ItemsPerPhase) begin
        random_read();
        if (!paused && items_sent >= ItemsPerPhase / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/idp_pkg.sv
rtl/idp_in_stage.sv
rtl/idp_core.sv
rtl/id_prom_crc_validator_top.sv
tb/sv/id_prom_crc_validator_checker.sv
tb/sv/tb_id_prom_crc_validator_top.sv
